// ===== sv/dhpq_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the
// hole-tolerant depth point query block. No dependencies.
package dhpq_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_RADIUS = 25;
  localparam int CAND_DEPTH = 4096;
  localparam int N_RADII    = 7;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int CI_W   = $clog2(CAND_DEPTH);
  localparam int CN_W   = CI_W + 1;
  localparam int R_W    = 5;
  localparam int K_W    = 3;

  localparam int DEPTH_W = 16;
  localparam int SCALE_W = 32;
  localparam int P_W     = DEPTH_W + SCALE_W;
  localparam int IMG_W   = 13;
  localparam int ABS_W   = 14;
  localparam int HALF_W  = P_W / 2;
  localparam int PP_W    = ABS_W + HALF_W;
  localparam int MAG_W   = 62;
  localparam int NUM_W   = MAG_W - 9;
  localparam int CFG_W   = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_MAP_WIDTH    = 3'd0,
    CFG_MAP_HEIGHT   = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_UNIT_SCALE   = 3'd4,
    CFG_MAP_ALIGNED  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic store_wr;
    logic load_query;
    logic set_bad;
    logic set_empty;
    logic rad_start;
    logic rad_next;
    logic scan_step;
    logic sel_init;
    logic sel_step;
    logic sel_bit;
    logic mul_p;
    logic mul_axis;
    logic sum;
    logic div_start;
    logic div_take;
    logic axis;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic oob;
    logic rad_ok;
    logic k_last;
    logic scan_last;
    logic n_ge3;
    logic n_zero;
    logic sel_last;
    logic bit_last;
    logic div_done;
  } dp_sts_t;

  function automatic logic [R_W-1:0] radius_of(logic [K_W-1:0] k);
    logic [R_W-1:0] r;
    case (k)
      3'd0: r = 5'd1;
      3'd1: r = 5'd2;
      3'd2: r = 5'd3;
      3'd3: r = 5'd5;
      3'd4: r = 5'd10;
      3'd5: r = 5'd15;
      3'd6: r = 5'd25;
      default: r = 5'd25;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dhpq_if.sv =====
// Valid/ready channel interfaces for query input and point result.
// Depends on dhpq_pkg.
interface dhpq_in_if import dhpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [X_W-1:0]   coord_x;
  logic [Y_W-1:0]   coord_y;
  logic [15:0]      depth_in;
  logic [5:0]       radius_limit;
  modport source (output valid, op, coord_x, coord_y, depth_in, radius_limit, input ready);
  modport sink   (input valid, op, coord_x, coord_y, depth_in, radius_limit, output ready);
endinterface

interface dhpq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [30:0]        point_z;
  modport source (output valid, status, point_x, point_y, point_z, input ready);
  modport sink   (input valid, status, point_x, point_y, point_z, output ready);
endinterface

// ===== sv/dhpq_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on dhpq_pkg.
module dhpq_div import dhpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [IMG_W-1:0]  den,
  output logic              done,
  output logic [31:0]       quo,
  output logic              ovf
);

  logic [IMG_W-1:0] rem_r;
  logic [31:0]      sh_r;
  logic [31:0]      quo_r;
  logic             ovf_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [IMG_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, sh_r[31]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd31;
      ovf_r  <= num >= {(NUM_W - IMG_W - 32)'(0), den, 32'd0};
      rem_r  <= num[32 +: IMG_W];
      sh_r   <= num[31:0];
    end else if (busy_r) begin
      rem_r <= ge ? IMG_W'(trial - {1'b0, den}) : trial[IMG_W-1:0];
      sh_r  <= {sh_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], ge};
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

// ===== sv/dhpq_dp.sv =====
// Datapath: config registers, depth store, window scan, candidate buffer,
// radix selection, scaling and back-projection. Depends on dhpq_pkg, dhpq_div.
module dhpq_dp import dhpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [X_W-1:0]     in_x,
  input  logic [Y_W-1:0]     in_y,
  input  logic [15:0]        in_depth,
  input  logic [5:0]         in_rlim,
  output logic [1:0]         res_status,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic [30:0]        res_z
);

  // configuration
  logic [10:0]        map_w_r;
  logic [9:0]         map_h_r;
  logic [IMG_W-1:0]   img_w_r, img_h_r;
  logic [SCALE_W-1:0] scale_r;
  logic               aligned_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r   <= 11'd640;
      map_h_r   <= 10'd480;
      img_w_r   <= 13'd640;
      img_h_r   <= 13'd480;
      scale_r   <= 32'd16777;
      aligned_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MAP_WIDTH:    map_w_r   <= cfg_data[10:0];
        CFG_MAP_HEIGHT:   map_h_r   <= cfg_data[9:0];
        CFG_IMAGE_WIDTH:  img_w_r   <= cfg_data[IMG_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r   <= cfg_data[IMG_W-1:0];
        CFG_UNIT_SCALE:   scale_r   <= cfg_data;
        CFG_MAP_ALIGNED:  aligned_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // query and window
  logic [X_W-1:0] qx_r, x0_r, x1_r, cx_r;
  logic [Y_W-1:0] qy_r, y0_r, y1_r, cy_r;
  logic [5:0]     rlim_r;
  logic [K_W-1:0] k_r;
  logic [R_W-1:0] rad;
  logic [X_W:0]   w_eff, x_hi;
  logic [Y_W:0]   h_eff, y_hi;
  status_t        code_r;

  assign rad   = radius_of(k_r);
  assign w_eff = (map_w_r > 11'(MAX_WIDTH)) ? (X_W+1)'(MAX_WIDTH) : (X_W+1)'(map_w_r);
  assign h_eff = (map_h_r > 10'(MAX_HEIGHT)) ? (Y_W+1)'(MAX_HEIGHT) : (Y_W+1)'(map_h_r);
  assign x_hi  = (X_W+1)'(qx_r) + (X_W+1)'(rad);
  assign y_hi  = (Y_W+1)'(qy_r) + (Y_W+1)'(rad);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      code_r <= ST_OK;
    end else begin
      if (cmd.load_query) begin
        qx_r   <= in_x;
        qy_r   <= in_y;
        rlim_r <= in_rlim;
        k_r    <= '0;
        code_r <= ST_OK;
      end
      if (cmd.set_bad)   code_r <= ST_BAD;
      if (cmd.set_empty) code_r <= ST_EMPTY;
      if (cmd.rad_next)  k_r <= k_r + 3'd1;
      if (cmd.rad_start) begin
        x0_r <= (qx_r >= X_W'(rad)) ? qx_r - X_W'(rad) : '0;
        y0_r <= (qy_r >= Y_W'(rad)) ? qy_r - Y_W'(rad) : '0;
        x1_r <= (x_hi > w_eff - 1'b1) ? X_W'(w_eff - 1'b1) : x_hi[X_W-1:0];
        y1_r <= (y_hi > h_eff - 1'b1) ? Y_W'(h_eff - 1'b1) : y_hi[Y_W-1:0];
        cx_r <= (qx_r >= X_W'(rad)) ? qx_r - X_W'(rad) : '0;
        cy_r <= (qy_r >= Y_W'(rad)) ? qy_r - Y_W'(rad) : '0;
      end else if (cmd.scan_step) begin
        if (cx_r == x1_r) begin
          cx_r <= x0_r;
          cy_r <= cy_r + 1'b1;
        end else begin
          cx_r <= cx_r + 1'b1;
        end
      end
    end
  end

  // depth store: writes only while idle, reads only while scanning
  logic [15:0] dstore [0:(2**ADDR_W)-1];
  logic [15:0] drd_r;
  logic        drv_r;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) dstore[{in_y, in_x}] <= in_depth;
    if (cmd.scan_step) drd_r <= dstore[{cy_r, cx_r}];
  end

  // candidate buffer
  logic [15:0]     cand [0:CAND_DEPTH-1];
  logic [15:0]     crd_r;
  logic            crv_r;
  logic [CN_W-1:0] n_r, rank_r, cnt_r;
  logic [CI_W-1:0] i_r;
  logic [3:0]      bit_r;
  logic [15:0]     prefix_r, hi_mask;
  logic            cap, match;

  assign cap     = drv_r && (drd_r != 16'd0) && (n_r < CN_W'(CAND_DEPTH));
  assign hi_mask = 16'hFFFF << (5'(bit_r) + 5'd1);
  assign match   = crv_r && (((crd_r ^ prefix_r) & hi_mask) == 16'd0) && !crd_r[bit_r];

  always_ff @(posedge clk) begin
    if (cap) cand[n_r[CI_W-1:0]] <= drd_r;
    if (cmd.sel_step) crd_r <= cand[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_r <= 1'b0;
      crv_r <= 1'b0;
      n_r   <= '0;
    end else begin
      drv_r <= cmd.scan_step;
      crv_r <= cmd.sel_step;
      if (cmd.load_query || cmd.rad_start) n_r <= '0;
      else if (cap) n_r <= n_r + 1'b1;
      if (cmd.sel_init) begin
        i_r      <= '0;
        bit_r    <= 4'd15;
        prefix_r <= '0;
        rank_r   <= n_r >> 2;
        cnt_r    <= '0;
      end else if (cmd.sel_bit) begin
        i_r   <= '0;
        cnt_r <= '0;
        bit_r <= bit_r - 4'd1;
        if (rank_r >= cnt_r) begin
          prefix_r[bit_r] <= 1'b1;
          rank_r          <= rank_r - cnt_r;
        end
      end else begin
        if (cmd.sel_step) i_r <= i_r + 1'b1;
        if (match) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // scaling and projection
  logic [P_W-1:0]      p_r;
  logic [PP_W-1:0]     pl_r, ph_r;
  logic                neg_r;
  logic [30:0]         z_r;
  logic [NUM_W-1:0]    num_r;
  logic signed [31:0]  px_r, py_r;
  logic [IMG_W-1:0]    fx;
  logic signed [15:0]  dsig;
  logic [ABS_W-1:0]    dabs;
  logic [P_W:0]        zsum;
  logic [MAG_W-1:0]    mag;
  logic                div_done, div_ovf;
  logic [31:0]         div_quo;
  logic [31:0]         proj;

  assign fx   = (img_w_r == '0) ? IMG_W'(1) : img_w_r;
  assign dsig = cmd.axis ? $signed(16'({qy_r, 1'b0})) - $signed(16'(img_h_r))
                         : $signed(16'({qx_r, 1'b0})) - $signed(16'(img_w_r));
  assign dabs = dsig[15] ? ABS_W'(-dsig) : ABS_W'(dsig);
  assign zsum = (P_W+1)'(p_r) + (P_W+1)'(128);
  assign mag  = MAG_W'(pl_r) + (MAG_W'(ph_r) << HALF_W) + MAG_W'({fx, 8'd0});

  always_comb begin
    if (neg_r) proj = (div_ovf || div_quo > 32'h8000_0000) ? 32'h8000_0000 : -div_quo;
    else       proj = (div_ovf || div_quo[31]) ? 32'h7FFF_FFFF : div_quo;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_p) p_r <= prefix_r * scale_r;
    if (cmd.mul_axis) begin
      pl_r  <= dabs * p_r[HALF_W-1:0];
      ph_r  <= dabs * p_r[P_W-1:HALF_W];
      neg_r <= dsig[15];
      z_r   <= (zsum[P_W:8] > (P_W-7)'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : zsum[38:8];
    end
    if (cmd.sum) num_r <= mag[MAG_W-1:9];
    if (cmd.div_take) begin
      if (cmd.axis) py_r <= $signed(proj);
      else          px_r <= $signed(proj);
    end
    if (cmd.out_load) begin
      res_status <= code_r;
      res_x      <= (code_r == ST_OK) ? px_r : '0;
      res_y      <= (code_r == ST_OK) ? py_r : '0;
      res_z      <= (code_r == ST_OK) ? z_r  : '0;
    end
  end

  dhpq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (fx),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // status to controller
  always_comb begin
    sts.oob       = !aligned_r || ((X_W+1)'(qx_r) >= w_eff) || ((Y_W+1)'(qy_r) >= h_eff);
    sts.rad_ok    = (6'(rad) <= rlim_r) && (rad <= R_W'(MAX_RADIUS));
    sts.k_last    = (k_r == K_W'(N_RADII - 1));
    sts.scan_last = (cx_r == x1_r) && (cy_r == y1_r);
    sts.n_ge3     = (n_r >= CN_W'(3));
    sts.n_zero    = (n_r == '0);
    sts.sel_last  = (CN_W'(i_r) == n_r - 1'b1);
    sts.bit_last  = (bit_r == 4'd0);
    sts.div_done  = div_done;
  end

endmodule

// ===== sv/dhpq_ctrl.sv =====
// Sequencer for writes and queries: drives datapath commands, owns the
// handshake flags. Depends on dhpq_pkg.
module dhpq_ctrl import dhpq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RAD_CHK, S_SCAN, S_DRAIN, S_EVAL,
    S_SEL_SCAN, S_SEL_DRAIN, S_SEL_BIT, S_MUL_P,
    S_MUL_X, S_SUM_X, S_DST_X, S_DIV_X,
    S_MUL_Y, S_SUM_Y, S_DST_Y, S_DIV_Y, S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.axis      = (state_r == S_MUL_Y) || (state_r == S_DIV_Y);
    case (state_r)
      S_IDLE: begin
        cmd.store_wr   = accept && (in_op == OP_WRITE);
        cmd.load_query = accept && (in_op == OP_QUERY);
        if (cmd.load_query) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.oob) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          state_nxt = S_RAD_CHK;
        end
      end
      S_RAD_CHK: begin
        if (sts.rad_ok) begin
          cmd.rad_start = 1'b1;
          state_nxt     = S_SCAN;
        end else if (sts.k_last) begin
          state_nxt = S_EVAL;
        end else begin
          cmd.rad_next = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.n_ge3 || sts.k_last) begin
          if (sts.n_zero) begin
            cmd.set_empty = 1'b1;
            state_nxt     = S_RESULT;
          end else begin
            cmd.sel_init = 1'b1;
            state_nxt    = S_SEL_SCAN;
          end
        end else begin
          cmd.rad_next = 1'b1;
          state_nxt    = S_RAD_CHK;
        end
      end
      S_SEL_SCAN: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_last) state_nxt = S_SEL_DRAIN;
      end
      S_SEL_DRAIN: state_nxt = S_SEL_BIT;
      S_SEL_BIT: begin
        cmd.sel_bit = 1'b1;
        state_nxt   = sts.bit_last ? S_MUL_P : S_SEL_SCAN;
      end
      S_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.mul_axis = 1'b1;
        state_nxt    = S_SUM_X;
      end
      S_SUM_X: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DST_X;
      end
      S_DST_X: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_X;
      end
      S_DIV_X: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_MUL_Y;
        end
      end
      S_MUL_Y: begin
        cmd.mul_axis = 1'b1;
        state_nxt    = S_SUM_Y;
      end
      S_SUM_Y: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DST_Y;
      end
      S_DST_Y: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_Y;
      end
      S_DIV_Y: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/depth_hole_tolerant_point_query.sv =====
// Top level of the hole-tolerant depth point query block.
// Depends on dhpq_pkg, dhpq_if, dhpq_ctrl, dhpq_dp, dhpq_div.
//
// Usage:
//   in_ch  (valid/ready) carries transactions: op=0 writes depth_in at
//          (coord_x, coord_y); op=1 queries a point with radius_limit.
//   out_ch (valid/ready) returns one transaction per query: status and
//          the Q16.16 camera point. Writes give no result.
//   cfg_*  plain write port; write only while the block is idle.
// Throughput:
//   Writes stream back to back.
//   A query holds off new transactions until its result is loaded. The
//   window scan reads one pixel per cycle from the single-port depth
//   store; selection walks the candidate buffer once per depth bit; the
//   divider yields one bit per cycle.
// Reset: config registers return to defaults, controller idles, output
//   empty. The depth store is not cleared: pixels must be written first.
// Stall: a finished result sits in the output register; writes are still
//   accepted meanwhile, and the next query waits there for a free slot.
module depth_hole_tolerant_point_query import dhpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  dhpq_in_if.sink          in_ch,
  dhpq_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: sequence of scan, select, scale, divide
  dhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: storage and arithmetic
  dhpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_x       (in_ch.coord_x),
    .in_y       (in_ch.coord_y),
    .in_depth   (in_ch.depth_in),
    .in_rlim    (in_ch.radius_limit),
    .res_status (out_ch.status),
    .res_x      (out_ch.point_x),
    .res_y      (out_ch.point_y),
    .res_z      (out_ch.point_z)
  );

`ifndef SYNTHESIS
  // a query occupies the block: no new transaction the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_QUERY) |=> !in_ch.ready)
    else $error("input accepted right after a query");

  // failed queries carry zero point fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |->
      (out_ch.point_x == 0 && out_ch.point_y == 0 && out_ch.point_z == 0))
    else $error("nonzero point with failing status");

  // a write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_WRITE && !out_ch.valid) |=> !out_ch.valid)
    else $error("result after a depth write");
`endif

endmodule
